### hdl/ndvi_pkg.sv
`default_nettype none

package ndvi_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 14;
    localparam int SUM_BITS    = SAMPLE_BITS + 1;
    localparam int REM_BITS    = SAMPLE_BITS + 2;
    localparam int Q_BITS      = FRAC_BITS + 1;
    localparam int NDVI_BITS   = 16;
    localparam int CMP_BITS    = (Q_BITS + 1 > NDVI_BITS) ? Q_BITS + 1 : NDVI_BITS;
    localparam int CH_BITS     = 8;
    localparam int PROD_BITS   = Q_BITS + CH_BITS + 1;
    localparam int LATENCY     = Q_BITS + 3;

    typedef logic [CH_BITS-1:0]   chan_t;
    typedef logic [PROD_BITS-1:0] prod_t;

    localparam prod_t ROUND_UP = prod_t'((64'd1 << FRAC_BITS) - 64'd1);

    // water ramp (negative NDVI), rising channels
    localparam chan_t UP_BASE_B  = 8'd150;
    localparam chan_t UP_BASE_G  = 8'd100;
    localparam chan_t UP_BASE_R  = 8'd50;
    localparam chan_t UP_DELTA_B = 8'd50;
    localparam chan_t UP_DELTA_G = 8'd120;
    localparam chan_t UP_DELTA_R = 8'd130;

    // green ramp (zero or positive NDVI), falling channels
    localparam chan_t DN_BASE_B  = 8'd20;
    localparam chan_t DN_BASE_G  = 8'd220;
    localparam chan_t DN_BASE_R  = 8'd20;
    localparam chan_t DN_DELTA_B = 8'd20;
    localparam chan_t DN_DELTA_G = 8'd140;
    localparam chan_t DN_DELTA_R = 8'd20;

endpackage

`default_nettype wire

### hdl/ndvi_pixel_classifier_top.sv
// Channel     | Ports                                              | Handshake
// ------------+----------------------------------------------------+-------------------------
// pixel in    | red_sample, nir_sample                             | start && !busy
// result out  | ndvi_level, algae_flag, zero_sum, color_blue/green/red | done, one-cycle strobe
// threshold   | threshold_wdata                                    | threshold_we
//
// One word per clock; busy never rises.
// From accept to done a word passes stage 0, the divider stages, stage M and stage F.
// Latency is set by the restoring divider, one quotient bit per pipeline stage.
// rst_n clears valid bits and the threshold (to 0); payload registers are not reset.
// The receiver cannot stall; results leave on done without back-pressure.
`default_nettype none

module ndvi_pixel_classifier_top (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output      logic                                   busy,
    input  wire logic [ndvi_pkg::SAMPLE_BITS-1:0]       red_sample,
    input  wire logic [ndvi_pkg::SAMPLE_BITS-1:0]       nir_sample,
    input  wire logic                                   threshold_we,
    input  wire logic signed [ndvi_pkg::NDVI_BITS-1:0]  threshold_wdata,
    output      logic                                   done,
    output      logic signed [ndvi_pkg::NDVI_BITS-1:0]  ndvi_level,
    output      logic                                   algae_flag,
    output      logic                                   zero_sum,
    output      logic [ndvi_pkg::CH_BITS-1:0]           color_blue,
    output      logic [ndvi_pkg::CH_BITS-1:0]           color_green,
    output      logic [ndvi_pkg::CH_BITS-1:0]           color_red
);
    import ndvi_pkg::*;

    // threshold register
    logic signed [NDVI_BITS-1:0] threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (threshold_we)
        begin
            threshold_reg <= threshold_wdata;
        end
    end

    // stage 0: sum, difference, sign
    logic                   s0_valid_reg;
    logic [SUM_BITS-1:0]    s0_sum_reg, s0_sum_next;
    logic [SAMPLE_BITS-1:0] s0_diff_reg, s0_diff_next;
    logic                   s0_neg_reg, s0_neg_next;
    logic                   s0_zero_reg, s0_zero_next;
    logic                   accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        s0_sum_next  = {1'b0, red_sample} + {1'b0, nir_sample};
        s0_neg_next  = red_sample > nir_sample;
        s0_diff_next = s0_neg_next ? red_sample - nir_sample : nir_sample - red_sample;
        s0_zero_next = (s0_sum_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_sum_reg  <= s0_sum_next;
        s0_diff_reg <= s0_diff_next;
        s0_neg_reg  <= s0_neg_next;
        s0_zero_reg <= s0_zero_next;
    end

    // divider: one quotient bit per stage, MSB first
    // (diff << FRAC_BITS) / sum; higher quotient bits are zero since diff <= sum
    logic                dv_valid_reg [Q_BITS];
    logic [REM_BITS-1:0] dv_rem_reg   [Q_BITS];
    logic [REM_BITS-1:0] dv_rem_next  [Q_BITS];
    logic [SUM_BITS-1:0] dv_den_reg   [Q_BITS];
    logic [Q_BITS-1:0]   dv_q_reg     [Q_BITS];
    logic [Q_BITS-1:0]   dv_q_next    [Q_BITS];
    logic                dv_neg_reg   [Q_BITS];
    logic                dv_zero_reg  [Q_BITS];

    for (genvar k = 0; k < Q_BITS; k++)
    begin : g_div
        logic                valid_in;
        logic [REM_BITS-1:0] rem_in;
        logic [SUM_BITS-1:0] den_in;
        logic [Q_BITS-1:0]   q_in;
        logic                neg_in;
        logic                zero_in;
        logic [REM_BITS-1:0] trial;
        logic                take;

        if (k == 0)
        begin : g_first
            assign valid_in = s0_valid_reg;
            assign rem_in   = REM_BITS'(s0_diff_reg);
            assign den_in   = s0_sum_reg;
            assign q_in     = '0;
            assign neg_in   = s0_neg_reg;
            assign zero_in  = s0_zero_reg;
        end
        else
        begin : g_next
            assign valid_in = dv_valid_reg[k-1];
            assign rem_in   = {dv_rem_reg[k-1][REM_BITS-2:0], 1'b0};
            assign den_in   = dv_den_reg[k-1];
            assign q_in     = dv_q_reg[k-1];
            assign neg_in   = dv_neg_reg[k-1];
            assign zero_in  = dv_zero_reg[k-1];
        end

        always_comb
        begin
            trial          = rem_in - REM_BITS'(den_in);
            take           = rem_in >= REM_BITS'(den_in);
            dv_rem_next[k] = take ? trial : rem_in;
            dv_q_next[k]   = {q_in[Q_BITS-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[k]  <= dv_rem_next[k];
            dv_den_reg[k]  <= den_in;
            dv_q_reg[k]    <= dv_q_next[k];
            dv_neg_reg[k]  <= neg_in;
            dv_zero_reg[k] <= zero_in;
        end
    end

    // stage M: sign, threshold compare, ramp products
    logic                       m_valid_reg;
    logic [NDVI_BITS-1:0]       m_ndvi_reg;
    logic                       m_algae_reg, m_algae_next;
    logic                       m_zero_reg;
    logic                       m_up_reg, m_up_next;
    prod_t                      m_prod_b_reg, m_prod_b_next;
    prod_t                      m_prod_g_reg, m_prod_g_next;
    prod_t                      m_prod_r_reg, m_prod_r_next;
    logic [Q_BITS-1:0]          mag;
    logic signed [CMP_BITS-1:0] ndvi_full;
    logic signed [CMP_BITS-1:0] thr_ext;
    logic                       last_neg;
    logic                       last_zero;

    assign last_neg  = dv_neg_reg[Q_BITS-1];
    assign last_zero = dv_zero_reg[Q_BITS-1];

    always_comb
    begin
        mag           = last_zero ? '0 : dv_q_reg[Q_BITS-1];
        ndvi_full     = last_neg ? -$signed(CMP_BITS'(mag)) : $signed(CMP_BITS'(mag));
        thr_ext       = CMP_BITS'(threshold_reg);
        m_algae_next  = ndvi_full > thr_ext;
        m_up_next     = last_neg && (mag != '0);
        m_prod_b_next = prod_t'(mag) * prod_t'(m_up_next ? UP_DELTA_B : DN_DELTA_B);
        m_prod_g_next = prod_t'(mag) * prod_t'(m_up_next ? UP_DELTA_G : DN_DELTA_G);
        m_prod_r_next = prod_t'(mag) * prod_t'(m_up_next ? UP_DELTA_R : DN_DELTA_R);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= dv_valid_reg[Q_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        m_ndvi_reg   <= ndvi_full[NDVI_BITS-1:0];
        m_algae_reg  <= m_algae_next;
        m_zero_reg   <= last_zero;
        m_up_reg     <= m_up_next;
        m_prod_b_reg <= m_prod_b_next;
        m_prod_g_reg <= m_prod_g_next;
        m_prod_r_reg <= m_prod_r_next;
    end

    // stage F: colour channels, output register
    logic                 f_valid_reg;
    logic [NDVI_BITS-1:0] f_ndvi_reg;
    logic                 f_algae_reg;
    logic                 f_zero_reg;
    chan_t                f_b_reg, f_b_next;
    chan_t                f_g_reg, f_g_next;
    chan_t                f_r_reg, f_r_next;

    always_comb
    begin
        if (m_up_reg)
        begin
            f_b_next = UP_BASE_B + chan_t'(m_prod_b_reg >> FRAC_BITS);
            f_g_next = UP_BASE_G + chan_t'(m_prod_g_reg >> FRAC_BITS);
            f_r_next = UP_BASE_R + chan_t'(m_prod_r_reg >> FRAC_BITS);
        end
        else
        begin
            f_b_next = DN_BASE_B - chan_t'((m_prod_b_reg + ROUND_UP) >> FRAC_BITS);
            f_g_next = DN_BASE_G - chan_t'((m_prod_g_reg + ROUND_UP) >> FRAC_BITS);
            f_r_next = DN_BASE_R - chan_t'((m_prod_r_reg + ROUND_UP) >> FRAC_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f_ndvi_reg  <= m_ndvi_reg;
        f_algae_reg <= m_algae_reg;
        f_zero_reg  <= m_zero_reg;
        f_b_reg     <= f_b_next;
        f_g_reg     <= f_g_next;
        f_r_reg     <= f_r_next;
    end

    assign done        = f_valid_reg;
    assign ndvi_level  = $signed(f_ndvi_reg);
    assign algae_flag  = f_algae_reg;
    assign zero_sum    = f_zero_reg;
    assign color_blue  = f_b_reg;
    assign color_green = f_g_reg;
    assign color_red   = f_r_reg;

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("word accepted but no result after pipeline latency");

    a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without matching accepted word");

    a_zero_ndvi : assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_sum |-> ndvi_level == '0)
        else $error("zero sum must give zero NDVI");

    a_zero_colour : assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_sum |-> color_blue == DN_BASE_B && color_green == DN_BASE_G
                             && color_red == DN_BASE_R)
        else $error("zero sum must map to green ramp start colour");

    a_neg_water : assert property (@(posedge clk) disable iff (!rst_n)
        done && ndvi_level[NDVI_BITS-1] |-> color_blue >= UP_BASE_B)
        else $error("negative NDVI must use the water ramp");

endmodule

`default_nettype wire
